### hw/rtl/ncci_pkg.sv
// ----------------------------------------------------------------------------
// ncci_pkg
// Shared widths, register indexes and inter-module types for the normal
// compliance contact impulse block.
// ----------------------------------------------------------------------------
package ncci_pkg;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int FRONT_STAGES = 7;

    // long division: 128-bit numerator, 64-bit divisor, 63 quotient bits
    localparam int NUM_W      = 128;
    localparam int DEN_W      = 64;
    localparam int QUO_W      = 63;
    localparam int DIV_STAGES = QUO_W + 1;

    localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 2'd2;

    localparam logic [31:0] STIFFNESS_RST = 32'd1000000;
    localparam logic [31:0] DAMPING_RST   = 32'd0;
    localparam logic [31:0] TIME_STEP_RST = 32'd4294967;

    localparam logic [62:0] MAX63   = {63{1'b1}};
    localparam logic [63:0] MIN64   = {1'b1, 63'd0};

    typedef struct packed {
        logic [31:0] k;
        logic [31:0] c;
        logic [31:0] t;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] nf;
        logic [NUM_W-1:0] ns;
        logic [NUM_W-1:0] nl;
        logic [DEN_W-1:0] df;
        logic [DEN_W-1:0] ds;
        logic [DEN_W-1:0] dl;
    } div_req_t;

    typedef struct packed {
        logic [62:0] e_start;
        logic [62:0] e_end;
        logic        force_ovf;
        logic [62:0] force_both;
        logic [62:0] slope_both;
        logic [60:0] damp;
        logic [55:0] cq;
        logic        both;
    } side_t;

endpackage

### hw/rtl/normal_compliance_contact_impulse.sv
// ----------------------------------------------------------------------------
// normal_compliance_contact_impulse
// Penalty-spring contact with a compression-only dashpot over one step.
// ----------------------------------------------------------------------------
// The block takes one word per clock and returns one word per accepted word,
// in order. The path is seven front stages (capture, branch decode, three
// levels of 32-bit multiplies and their sums), 64 stages of the long divider
// and the output register. The divider pipeline retires one quotient bit per
// stage, which sets the depth; throughput stays at one word per cycle while
// m_tready does not stall. A stall on m_tready freezes the whole pipeline in
// place, so nothing is lost or repeated. Registers take effect for words
// accepted after the write and must only be written while no word is in
// flight.
module normal_compliance_contact_impulse (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ncci_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ncci_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,  // gap_before, gap_change
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // impulse, impulse_slope, energy_start, energy_end, damping_loss, pad
    output logic [319:0]                     m_tdata
);
    import ncci_pkg::*;

    cfg_t                  cfg_reg;
    logic                  en;
    logic                  f_valid;
    div_req_t              req;
    side_t                 f_side;
    side_t                 dside_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] dvalid_reg;
    logic [QUO_W-1:0]      fq, sq, lq;
    logic                  fovf, sovf, lovf;
    side_t                 sd;

    logic [62:0]  fval, sval;
    logic         fsat, ssat;
    logic [63:0]  imp_sum, slope_sum;
    logic [63:0]  impulse, impulse_slope;
    logic [62:0]  damping_loss;

    logic         m_valid_reg;
    logic [319:0] m_data_reg;

    // Advance every stage together whenever the output register can move.
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Register writes; an unknown index is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.k <= STIFFNESS_RST;
            cfg_reg.c <= DAMPING_RST;
            cfg_reg.t <= TIME_STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STIFFNESS: cfg_reg.k <= cfg_data;
                REG_DAMPING:   cfg_reg.c <= cfg_data;
                REG_TIME_STEP: cfg_reg.t <= cfg_data;
                default: ;
            endcase
        end
    end

    ncci_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .gap_before (s_tdata[31:0]),
        .gap_change (s_tdata[63:32]),
        .cfg        (cfg_reg),
        .out_valid  (f_valid),
        .req        (req),
        .side       (f_side)
    );

    // Spring force for the transition branches: numerator over d*2^29.
    ncci_div u_div_force (
        .aclk (aclk),
        .en   (en),
        .num  (req.nf),
        .den  (req.df),
        .quo  (fq),
        .ovf  (fovf)
    );

    // Force derivative for the transition branches: numerator over 2*d^2.
    ncci_div u_div_slope (
        .aclk (aclk),
        .en   (en),
        .num  (req.ns),
        .den  (req.ds),
        .quo  (sq),
        .ovf  (sovf)
    );

    // Dashpot loss over the step length; a zero step overflows unless the
    // numerator is zero too.
    ncci_div u_div_loss (
        .aclk (aclk),
        .en   (en),
        .num  (req.nl),
        .den  (req.dl),
        .quo  (lq),
        .ovf  (lovf)
    );

    // Hold the undivided results beside the divider so they line up.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvalid_reg <= '0;
        end else if (en) begin
            dvalid_reg <= {dvalid_reg[DIV_STAGES-2:0], f_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dside_reg[0] <= f_side;
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                dside_reg[j] <= dside_reg[j-1];
            end
        end
    end

    // Combine branch terms, add the damping parts and saturate.
    always_comb begin
        sd   = dside_reg[DIV_STAGES-1];
        fval = sd.both ? sd.force_both : fq;
        fsat = sd.both ? sd.force_ovf : fovf;
        sval = sd.both ? sd.slope_both : sq;
        ssat = !sd.both && sovf;

        imp_sum = 64'(fval) + 64'(sd.damp);
        impulse = (fsat || imp_sum[63]) ? {1'b0, MAX63} : imp_sum;

        // the slope magnitude is negated; anything beyond 2^63 clips
        slope_sum     = 64'(sval) + 64'(sd.cq);
        impulse_slope = (ssat || (slope_sum > MIN64)) ? MIN64 : (64'd0 - slope_sum);

        damping_loss = lovf ? MAX63 : lq;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dvalid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {3'd0, damping_loss, sd.e_end, sd.e_start,
                           impulse_slope, impulse};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Impulse is clipped to the positive range and never goes negative.
    a_impulse_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[63])
        else $error("impulse sign bit set");

    // The slope is a negated magnitude: negative or zero.
    a_slope_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[127] || (m_tdata[127:64] == 64'd0)))
        else $error("impulse slope positive");

    // A stall must freeze the divider-side valid bits.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(dvalid_reg))
        else $error("pipeline moved during stall");

endmodule

### hw/rtl/ncci_div.sv
// ----------------------------------------------------------------------------
// ncci_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detection for quotients of 2^63 and above.
// ----------------------------------------------------------------------------
module ncci_div (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [ncci_pkg::NUM_W-1:0] num,
    input  logic [ncci_pkg::DEN_W-1:0] den,
    output logic [ncci_pkg::QUO_W-1:0] quo,
    output logic                       ovf
);
    import ncci_pkg::*;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] bits;
        logic [DEN_W-1:0] den;
        logic             ovf;
        logic             nz;
    } stage_t;

    function automatic stage_t div_step(stage_t s);
        logic [DEN_W:0] r2;
        logic           ge;
        stage_t         o;
        r2 = {s.rem, s.bits[QUO_W-1]};
        ge = r2 >= {1'b0, s.den};
        o = s;
        o.rem  = ge ? DEN_W'(r2 - {1'b0, s.den}) : r2[DEN_W-1:0];
        o.bits = {s.bits[QUO_W-2:0], ge};
        return o;
    endfunction

    logic [NUM_W-QUO_W-1:0] hi;
    stage_t                 init;
    stage_t                 stage_reg [DIV_STAGES];

    // top bits of the numerator decide overflow before any step runs
    always_comb begin
        hi        = num[NUM_W-1:QUO_W];
        init.nz   = num != '0;
        init.ovf  = init.nz && (hi >= (NUM_W-QUO_W)'(den));
        init.rem  = hi[DEN_W-1:0];
        init.bits = num[QUO_W-1:0];
        init.den  = den;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg[0] <= init;
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[j] <= div_step(stage_reg[j-1]);
            end
        end
    end

    assign quo = stage_reg[DIV_STAGES-1].nz ? stage_reg[DIV_STAGES-1].bits : '0;
    assign ovf = stage_reg[DIV_STAGES-1].ovf;

endmodule

### hw/rtl/ncci_front.sv
// ----------------------------------------------------------------------------
// ncci_front
// Input capture, branch selection and the multiplier stages that build the
// division operands and the results that need no division.
// ----------------------------------------------------------------------------
module ncci_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         gap_before,
    input  logic [31:0]         gap_change,
    input  ncci_pkg::cfg_t      cfg,
    output logic                out_valid,
    output ncci_pkg::div_req_t  req,
    output ncci_pkg::side_t     side
);
    import ncci_pkg::*;

    logic [FRONT_STAGES-1:0] valid_reg;

    // stage 1
    logic [31:0] g0_reg, d_reg;

    // stage 2 logic
    logic [32:0] g1, a1, m, vs;
    logic [31:0] a0, ad, u;
    logic [33:0] sb;
    logic        g0_le0, g1_le0, both, enter, leave, cc_le0;

    logic [31:0] a0_2_reg, ad_2_reg, u_2_reg;
    logic [32:0] a1_2_reg, vs_2_reg, m_2_reg;
    logic [33:0] sb_2_reg;
    logic        both_2_reg, cqen_2_reg;

    // stage 3
    logic [63:0] pf_3_reg, e0_3_reg, kt_3_reg, dd_3_reg;
    logic [64:0] ps_3_reg, cm_3_reg;
    logic [65:0] e1_3_reg, pb_3_reg;
    logic [31:0] ad_3_reg;
    logic        both_3_reg, cqen_3_reg;

    // stage 4
    logic [63:0] pf_lo_4_reg, pf_hi_4_reg, ps_lo_4_reg, e0_lo_4_reg, e0_hi_4_reg;
    logic [63:0] e1_lo_4_reg, pb_lo_4_reg, cm_lo_4_reg, kt_4_reg, dd_4_reg;
    logic [64:0] ps_hi_4_reg, cm_hi_4_reg;
    logic [65:0] e1_hi_4_reg, pb_hi_4_reg;
    logic [31:0] ad_4_reg;
    logic [60:0] damp_4_reg;
    logic        both_4_reg, cqen_4_reg;

    // stage 5
    logic [95:0] pfk_5_reg, e0k_5_reg;
    logic [96:0] psk_5_reg, ln_5_reg;
    logic [97:0] e1k_5_reg, pbt_5_reg;
    logic [63:0] kt_5_reg, dd_5_reg;
    logic [31:0] ad_5_reg;
    logic [60:0] damp_5_reg;
    logic        both_5_reg, cqen_5_reg;

    // stage 6
    logic [63:0] pf0_6_reg, pf1_6_reg, pf2_6_reg, ps0_6_reg, ps1_6_reg, dd_6_reg;
    logic [64:0] ps2_6_reg;
    logic [96:0] ln_6_reg;
    logic [31:0] ad_6_reg;
    side_t       side_6_reg;

    // stage 7
    div_req_t    req_reg;
    side_t       side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    // branch decode and magnitudes
    always_comb begin
        g1     = {g0_reg[31], g0_reg} + {d_reg[31], d_reg};
        a0     = g0_reg[31] ? (~g0_reg + 32'd1) : 32'd0;
        a1     = g1[32] ? (~g1 + 33'd1) : 33'd0;
        ad     = d_reg[31] ? (~d_reg + 32'd1) : d_reg;
        g0_le0 = g0_reg[31] || (g0_reg == 32'd0);
        g1_le0 = g1[32] || (g1 == 33'd0);
        both   = g0_le0 && g1_le0;
        enter  = !g0_le0 && g1[32];
        leave  = g0_reg[31] && !g1_le0;
        u      = enter ? a1[31:0] : (leave ? a0 : 32'd0);
        vs     = enter ? ({1'b0, g0_reg} + {1'b0, ad}) : (leave ? {1'b0, a0} : 33'd0);
        sb     = both ? (34'(a0) + 34'(a1)) : 34'd0;
        if (both) begin
            m      = d_reg[31] ? {1'b0, ad} : 33'd0;
            cc_le0 = d_reg[31] || (d_reg == 32'd0);
        end else begin
            m      = (a1 > {1'b0, a0}) ? (a1 - {1'b0, a0}) : 33'd0;
            cc_le0 = a1 >= {1'b0, a0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g0_reg <= gap_before;
            d_reg  <= gap_change;

            a0_2_reg   <= a0;
            a1_2_reg   <= a1;
            ad_2_reg   <= ad;
            u_2_reg    <= u;
            vs_2_reg   <= vs;
            sb_2_reg   <= sb;
            m_2_reg    <= m;
            both_2_reg <= both;
            cqen_2_reg <= g1_le0 && cc_le0;

            pf_3_reg   <= 64'(u_2_reg) * 64'(u_2_reg);
            ps_3_reg   <= 65'(u_2_reg) * 65'(vs_2_reg);
            e0_3_reg   <= 64'(a0_2_reg) * 64'(a0_2_reg);
            e1_3_reg   <= 66'(a1_2_reg) * 66'(a1_2_reg);
            pb_3_reg   <= 66'(sb_2_reg) * 66'(cfg.k);
            kt_3_reg   <= 64'(cfg.k) * 64'(cfg.t);
            cm_3_reg   <= 65'(cfg.c) * 65'(m_2_reg);
            dd_3_reg   <= 64'(ad_2_reg) * 64'(ad_2_reg);
            ad_3_reg   <= ad_2_reg;
            both_3_reg <= both_2_reg;
            cqen_3_reg <= cqen_2_reg;

            // split the wide products into 32-bit slices
            pf_lo_4_reg <= 64'(pf_3_reg[31:0]) * 64'(cfg.k);
            pf_hi_4_reg <= 64'(pf_3_reg[63:32]) * 64'(cfg.k);
            ps_lo_4_reg <= 64'(ps_3_reg[31:0]) * 64'(cfg.k);
            ps_hi_4_reg <= 65'(ps_3_reg[64:32]) * 65'(cfg.k);
            e0_lo_4_reg <= 64'(e0_3_reg[31:0]) * 64'(cfg.k);
            e0_hi_4_reg <= 64'(e0_3_reg[63:32]) * 64'(cfg.k);
            e1_lo_4_reg <= 64'(e1_3_reg[31:0]) * 64'(cfg.k);
            e1_hi_4_reg <= 66'(e1_3_reg[65:32]) * 66'(cfg.k);
            pb_lo_4_reg <= 64'(pb_3_reg[31:0]) * 64'(cfg.t);
            pb_hi_4_reg <= 66'(pb_3_reg[65:32]) * 66'(cfg.t);
            cm_lo_4_reg <= 64'(cm_3_reg[31:0]) * 64'(ad_3_reg);
            cm_hi_4_reg <= 65'(cm_3_reg[64:32]) * 65'(ad_3_reg);
            kt_4_reg    <= kt_3_reg;
            dd_4_reg    <= dd_3_reg;
            ad_4_reg    <= ad_3_reg;
            damp_4_reg  <= cm_3_reg[64:4];
            both_4_reg  <= both_3_reg;
            cqen_4_reg  <= cqen_3_reg;

            pfk_5_reg  <= 96'(pf_lo_4_reg) + {pf_hi_4_reg, 32'd0};
            psk_5_reg  <= 97'(ps_lo_4_reg) + {ps_hi_4_reg, 32'd0};
            e0k_5_reg  <= 96'(e0_lo_4_reg) + {e0_hi_4_reg, 32'd0};
            e1k_5_reg  <= 98'(e1_lo_4_reg) + {e1_hi_4_reg, 32'd0};
            pbt_5_reg  <= 98'(pb_lo_4_reg) + {pb_hi_4_reg, 32'd0};
            ln_5_reg   <= 97'(cm_lo_4_reg) + {cm_hi_4_reg, 32'd0};
            kt_5_reg   <= kt_4_reg;
            dd_5_reg   <= dd_4_reg;
            ad_5_reg   <= ad_4_reg;
            damp_5_reg <= damp_4_reg;
            both_5_reg <= both_4_reg;
            cqen_5_reg <= cqen_4_reg;

            pf0_6_reg <= 64'(pfk_5_reg[31:0]) * 64'(cfg.t);
            pf1_6_reg <= 64'(pfk_5_reg[63:32]) * 64'(cfg.t);
            pf2_6_reg <= 64'(pfk_5_reg[95:64]) * 64'(cfg.t);
            ps0_6_reg <= 64'(psk_5_reg[31:0]) * 64'(cfg.t);
            ps1_6_reg <= 64'(psk_5_reg[63:32]) * 64'(cfg.t);
            ps2_6_reg <= 65'(psk_5_reg[96:64]) * 65'(cfg.t);
            ln_6_reg  <= ln_5_reg;
            dd_6_reg  <= dd_5_reg;
            ad_6_reg  <= ad_5_reg;
            side_6_reg.e_start    <= (e0k_5_reg[95:88] != '0) ? MAX63 : e0k_5_reg[87:25];
            side_6_reg.e_end      <= (e1k_5_reg[97:88] != '0) ? MAX63 : e1k_5_reg[87:25];
            side_6_reg.force_ovf  <= pbt_5_reg[97:92] != '0;
            side_6_reg.force_both <= pbt_5_reg[91:29];
            side_6_reg.slope_both <= kt_5_reg[63:1];
            side_6_reg.damp       <= damp_5_reg;
            side_6_reg.cq         <= cqen_5_reg ? {cfg.c, 24'd0} : 56'd0;
            side_6_reg.both       <= both_5_reg;

            req_reg.nf <= 128'(pf0_6_reg) + 128'({pf1_6_reg, 32'd0})
                        + 128'({pf2_6_reg, 64'd0});
            req_reg.ns <= 128'(ps0_6_reg) + 128'({ps1_6_reg, 32'd0})
                        + 128'({ps2_6_reg, 64'd0});
            req_reg.nl <= 128'(ln_6_reg);
            req_reg.df <= {3'd0, ad_6_reg, 29'd0};
            req_reg.ds <= {dd_6_reg[62:0], 1'b0};
            req_reg.dl <= 64'(cfg.t);
            side_reg   <= side_6_reg;
        end
    end

    assign out_valid = valid_reg[FRONT_STAGES-1];
    assign req       = req_reg;
    assign side      = side_reg;

endmodule

### sim/normal_compliance_contact_impulse_tb.sv
// ----------------------------------------------------------------------------
// normal_compliance_contact_impulse_tb
// Self-checking bench for the normal compliance contact impulse block.
// A directed table walks the contact branches and the field extremes under the
// reset settings. Random words then run under several register settings,
// including the extremes. Every output word is checked field by field against
// an in-bench predictor of the block, or a typed result for typed table rows.
// Bursty input, a stalling output and one long output hold-off exercise the back pressure paths.
// ----------------------------------------------------------------------------
module normal_compliance_contact_impulse_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ncci_pkg::*;

    localparam int LATENCY     = 72;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_ITEMS  = 1100;
    localparam int PHASES      = 6;

    typedef struct packed {
        logic [62:0] loss;
        logic [62:0] e_end;
        logic [62:0] e_start;
        logic [63:0] slope;
        logic [63:0] impulse;
    } contact_res_t;

    typedef struct {
        logic [31:0]  g0;
        logic [31:0]  d;
        bit           typed;
        contact_res_t res;
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // gap_before [31:0], gap_change [63:32]
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;   // impulse, impulse_slope, energy_start, energy_end, loss, pad

    // bench copy of the register file
    logic [31:0] k_reg, c_reg, t_reg;

    contact_res_t contact_expected[$];
    int           mismatches;
    int           words_in, words_out;
    int           cycles;
    int           hold_off;   // receiver long stall, in cycles
    bit           stall_on;

    normal_compliance_contact_impulse uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [62:0] clip63(logic [127:0] v);
        return (v > {65'd0, MAX63}) ? MAX63 : v[62:0];
    endfunction

    // Exact contact evaluation at full width, then truncation and saturation.
    function automatic contact_res_t contact_predict(logic [31:0] gb, logic [31:0] gd);
        logic signed [63:0] g0, d, g1, s0, s1, cc;
        logic [127:0] k, c, t, a0, a1, ad, m, force_q, slope_q, damp, num, q;
        bit           both;
        contact_res_t r;
        g0 = {{32{gb[31]}}, gb};
        d  = {{32{gd[31]}}, gd};
        g1 = g0 + d;
        s0 = (g0 < 0) ? g0 : 64'sd0;
        s1 = (g1 < 0) ? g1 : 64'sd0;
        k  = k_reg;
        c  = c_reg;
        t  = t_reg;
        a0 = 128'(-s0);
        a1 = 128'(-s1);
        ad = (d < 0) ? 128'(-d) : 128'(d);
        both    = (g0 <= 0) && (g1 <= 0);
        force_q = '0;
        slope_q = '0;
        if (both) begin
            force_q = (128'(-(g0 + g1)) * k * t) >> 29;
            slope_q = (k * t) >> 1;
        end else if (g0 > 0 && g1 < 0) begin
            // entering contact
            force_q = (a1 * a1 * k * t) / (ad << 29);
            slope_q = (a1 * (128'(g0) + ad) * k * t) / (2 * ad * ad);
        end else if (g0 < 0 && g1 > 0) begin
            // leaving contact
            force_q = (a0 * a0 * k * t) / (ad << 29);
            slope_q = (a0 * a0 * k * t) / (2 * ad * ad);
        end
        cc   = both ? d : (s1 - s0);
        m    = (cc < 0) ? 128'(-cc) : '0;
        damp = (c * m) >> 4;
        if (g1 <= 0 && cc <= 0)
            slope_q = slope_q + (c << 24);
        num = c * m * ad;
        if (t == 0)
            r.loss = (num != 0) ? MAX63 : '0;
        else begin
            q      = num / t;
            r.loss = clip63(q);
        end
        r.impulse = {1'b0, clip63(force_q + damp)};
        r.slope   = (slope_q > 128'h8000_0000_0000_0000) ? MIN64 : (64'd0 - slope_q[63:0]);
        r.e_start = clip63((a0 * a0 * k) >> 25);
        r.e_end   = clip63((a1 * a1 * k) >> 25);
        return r;
    endfunction

    task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch word %0d %s: expected %h got %h",
                         words_out, name, exp_v, got_v);
        end
    endtask

    // Output monitor: compare each accepted word with the oldest expectation.
    always @(posedge aclk) begin
        contact_res_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[316:0];
            if (contact_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %0d: %h", words_out, got);
            end else begin
                exp_r = contact_expected.pop_front();
                report_field("impulse", exp_r.impulse, got.impulse);
                report_field("impulse_slope", exp_r.slope, got.slope);
                report_field("energy_start", {1'b0, exp_r.e_start}, {1'b0, got.e_start});
                report_field("energy_end", {1'b0, exp_r.e_end}, {1'b0, got.e_end});
                report_field("damping_loss", {1'b0, exp_r.loss}, {1'b0, got.loss});
            end
            words_out++;
        end
    end

    // Receiver: own random stall pattern, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (!stall_on)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Stall pattern switches between quiet stretches and stalling stretches.
    initial begin
        stall_on = 1'b0;
        forever begin
            repeat ($urandom_range(20, 300)) @(posedge aclk);
            stall_on = ~stall_on;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(logic [31:0] g0, logic [31:0] d);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {d, g0};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        contact_expected.push_back(contact_predict(g0, d));
        words_in++;
        // random gap between bursts; drop valid only when a gap follows
        if ($urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
        end
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (contact_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_STIFFNESS) k_reg = val;
        else if (idx == REG_DAMPING) c_reg = val;
        else if (idx == REG_TIME_STEP) t_reg = val;
    endtask

    // Random word: mostly well-formed contact cases, some raw noise.
    task automatic pick_word(output logic [31:0] g0, output logic [31:0] d);
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: begin
                g0 = $urandom;
                d  = $urandom;
            end
            2, 3: begin   // entering contact
                g0 = $urandom_range(1, 1 << $urandom_range(1, 30));
                d  = -($urandom_range(1, 1 << $urandom_range(1, 30)));
            end
            4, 5: begin   // leaving contact
                g0 = -($urandom_range(1, 1 << $urandom_range(1, 30)));
                d  = $urandom_range(1, 1 << $urandom_range(1, 30));
            end
            6, 7: begin   // compressed at both ends
                g0 = -($urandom_range(0, 1 << $urandom_range(1, 29)));
                d  = $urandom_range(0, 1 << $urandom_range(1, 27));
                if ($urandom_range(0, 1)) d = -d;
                if ($signed(g0) + $signed(d) > 0) d = -d;
            end
            default: begin   // corners
                g0 = ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7fff_ffff;
                d  = ($urandom_range(0, 2) == 0) ? 32'h8000_0000 :
                     ($urandom_range(0, 1) ? 32'h7fff_ffff : $urandom);
            end
        endcase
    endtask

    stim_row_t rows[$];

    initial begin
        logic [31:0] g0, d;
        logic [31:0] kv, cv, tv;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        hold_off  = 0;
        mismatches = 0;
        words_in  = 0;
        words_out = 0;
        cycles    = 0;
        k_reg = STIFFNESS_RST;
        c_reg = DAMPING_RST;
        t_reg = TIME_STEP_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table under reset settings. Separated, not touching: all zero.
        rows = '{
            '{32'h1000_0000, 32'h0000_0000, 1'b1, '0},
            '{32'h7fff_ffff, 32'h7fff_ffff, 1'b1, '0},
            '{32'h0000_0001, 32'h0000_0000, 1'b1, '0},
            '{32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{32'h8000_0000, 32'h0000_0000, 1'b0, '0},
            '{32'h8000_0000, 32'h8000_0000, 1'b0, '0},
            '{32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
            '{32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
            '{32'h0000_0001, 32'hffff_fffe, 1'b0, '0},
            '{32'h1000_0000, 32'he000_0000, 1'b0, '0},
            '{32'hf000_0000, 32'h2000_0000, 1'b0, '0},
            '{32'hffff_ffff, 32'h0000_0002, 1'b0, '0},
            '{32'hf000_0000, 32'h1000_0000, 1'b0, '0},
            '{32'h0000_0000, 32'hf000_0000, 1'b0, '0},
            '{32'hf000_0000, 32'hff00_0000, 1'b0, '0},
            '{32'hf000_0000, 32'h0100_0000, 1'b0, '0},
            '{32'h1000_0000, 32'hf000_0000, 1'b0, '0},
            '{32'hffff_ffff, 32'hffff_ffff, 1'b0, '0}
        };
        foreach (rows[i]) begin
            send_word(rows[i].g0, rows[i].d);
            // typed rows override the predictor's answer
            if (rows[i].typed) begin
                contact_expected.pop_back();
                contact_expected.push_back(rows[i].res);
            end
        end
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin kv = 32'd1;          cv = 32'd0;          tv = 32'd1;          end
                1: begin kv = 32'hffff_ffff;  cv = 32'hffff_ffff;  tv = 32'hffff_ffff;  end
                2: begin kv = STIFFNESS_RST;  cv = 32'd2560;       tv = TIME_STEP_RST;  end
                3: begin kv = 32'd1;          cv = 32'hffff_ffff;  tv = 32'd1;          end
                default: begin
                    kv = $urandom_range(1, 32'hffff_ffff);
                    cv = $urandom;
                    tv = $urandom_range(1, 32'hffff_ffff);
                end
            endcase
            write_reg(REG_STIFFNESS, kv);
            write_reg(REG_DAMPING, cv);
            write_reg(REG_TIME_STEP, tv);
            for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
                // hold the output off for a long stretch while input keeps coming
                if (ph == 2 && n == 20) hold_off = 400;
                pick_word(g0, d);
                send_word(g0, d);
            end
            drain();
        end

        $display("covered %0d words in, %0d words out, %0d register settings",
                 words_in, words_out, PHASES + 1);
        $display("%0d mismatches, %0d cycles", mismatches, cycles);
        if (mismatches == 0 && contact_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
